// ----- sv/ucrf_pkg.sv -----
package ucrf_pkg;

   localparam int unsigned BUFFER_BYTES = 1048576;

   localparam int unsigned BYTE_W  = 8;
   localparam int unsigned PORT_W  = 16;
   localparam int unsigned POS_W   = 16;
   localparam int unsigned IHW_W   = 4;
   localparam int unsigned HOFS_W  = 6;
   localparam int unsigned MAGIC_W = 32;
   localparam int unsigned SIZE_W  = 13;
   localparam int unsigned BASE_W  = BYTE_W + SIZE_W;
   localparam int unsigned ADDR_W  = 20;
   localparam int unsigned FIT_W   = 25;
   localparam int unsigned CSR_IDX_W  = 2;
   localparam int unsigned CSR_DATA_W = 32;

   localparam logic [IHW_W-1:0]  IHL_MIN       = 4'd5;
   localparam logic [BYTE_W-1:0] UDP_PROTO     = 8'd17;
   localparam logic [POS_W-1:0]  PROTO_POS     = 16'd9;
   localparam logic [POS_W-1:0]  POS_MAX       = 16'hFFFF;
   localparam logic [POS_W-1:0]  PAYLOAD_OFS   = 16'd16;
   localparam logic [POS_W-1:0]  HDR_LAST      = 16'd15;
   localparam logic [SIZE_W-1:0] CHUNK_SIZE_RST = 13'd1024;

   // offsets from the start of the UDP header
   localparam logic [POS_W-1:0] REL_SPORT_HI = 16'd0;
   localparam logic [POS_W-1:0] REL_SPORT_LO = 16'd1;
   localparam logic [POS_W-1:0] REL_DPORT_HI = 16'd2;
   localparam logic [POS_W-1:0] REL_DPORT_LO = 16'd3;
   localparam logic [POS_W-1:0] REL_LEN_HI   = 16'd4;
   localparam logic [POS_W-1:0] REL_LEN_LO   = 16'd5;
   localparam logic [POS_W-1:0] REL_MAGIC0   = 16'd8;
   localparam logic [POS_W-1:0] REL_MAGIC1   = 16'd9;
   localparam logic [POS_W-1:0] REL_MAGIC2   = 16'd10;
   localparam logic [POS_W-1:0] REL_MAGIC3   = 16'd11;
   localparam logic [POS_W-1:0] REL_INDEX    = 16'd14;
   localparam logic [POS_W-1:0] REL_TOTAL    = 16'd15;

   localparam logic [CSR_IDX_W-1:0] CSR_LISTEN_PORT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAGIC_WORD  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CHUNK_SIZE  = 2'd2;

   typedef struct packed {
      logic [PORT_W-1:0]  listen_port;
      logic [MAGIC_W-1:0] magic_word;
      logic [SIZE_W-1:0]  chunk_size;
   } cfg_type;

   typedef struct packed {
      logic              write_enable;
      logic [ADDR_W-1:0] write_address;
      logic [BYTE_W-1:0] write_data;
      logic              packet_done;
      logic              packet_taken;
      logic              tensor_complete;
      logic [PORT_W-1:0] reply_port;
   } result_type;

endpackage

// ----- sv/ucrf_intf.sv -----
interface ucrf_req_if;
   logic                             valid;
   logic                             ready;
   logic [ucrf_pkg::BYTE_W-1:0]      packet_byte;
   logic                             end_of_packet;
   modport source (output valid, packet_byte, end_of_packet, input ready);
   modport sink (input valid, packet_byte, end_of_packet, output ready);
endinterface

interface ucrf_rsp_if;
   logic                             valid;
   logic                             ready;
   logic                             write_enable;
   logic [ucrf_pkg::ADDR_W-1:0]      write_address;
   logic [ucrf_pkg::BYTE_W-1:0]      write_data;
   logic                             packet_done;
   logic                             packet_taken;
   logic                             tensor_complete;
   logic [ucrf_pkg::PORT_W-1:0]      reply_port;
   modport source (output valid, write_enable, write_address, write_data, packet_done,
                   packet_taken, tensor_complete, reply_port, input ready);
   modport sink (input valid, write_enable, write_address, write_data, packet_done,
                 packet_taken, tensor_complete, reply_port, output ready);
endinterface

interface ucrf_csr_if;
   logic                             valid;
   logic                             ready;
   logic [ucrf_pkg::CSR_IDX_W-1:0]   index;
   logic [ucrf_pkg::CSR_DATA_W-1:0]  data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// ----- sv/udp_chunk_receive_filter_top.sv -----
// UDP chunk receive filter.
// req_ch carries an IPv4 packet one byte per transfer, starting at the IP
// header, with end_of_packet on the last byte. rsp_ch returns exactly one
// result per input byte: a buffer write for chunk payload bytes, and on the
// last byte the verdict (packet_taken, tensor_complete). reply_port always
// shows the source port learned from the last accepted chunk header.
// csr_ch writes listen_port (0), magic_word (1) and chunk_size (2); other
// indexes are ignored. Write registers only while no byte is in flight.
// Each accepted byte is captured in the input register; the result register
// then loads its parsed result, which transfers on rsp_ch from there.
// Throughput: one byte per cycle while rsp_ch does not stall;
// the parse of each byte is a single pass between the two registers.
// When rsp_ch stalls, the result register holds and the input register
// fills; req_ch.ready drops only when both are occupied.
// Reset clears the packet parser, the learned port, both pipeline stages
// and the registers to their defaults (chunk_size 1024, others 0).
module udp_chunk_receive_filter_top (
   input logic       clock,
   input logic       reset,
   ucrf_req_if.sink  req_ch,
   ucrf_rsp_if.source rsp_ch,
   ucrf_csr_if.sink  csr_ch
);
   import ucrf_pkg::*;

   cfg_type    cfg_ff, cfg_in;
   logic       s1_valid_ff;
   logic [BYTE_W-1:0] s1_byte_ff;
   logic       s1_eop_ff;
   logic       rsp_valid_ff;
   result_type rsp_ff, result;
   logic       advance;

   assign advance       = s1_valid_ff && (!rsp_valid_ff || rsp_ch.ready);
   assign req_ch.ready  = !s1_valid_ff || advance;
   assign csr_ch.ready  = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_ch.valid) begin
         unique case (csr_ch.index)
            CSR_LISTEN_PORT: cfg_in.listen_port = csr_ch.data[PORT_W-1:0];
            CSR_MAGIC_WORD:  cfg_in.magic_word  = csr_ch.data[MAGIC_W-1:0];
            CSR_CHUNK_SIZE:  cfg_in.chunk_size  = csr_ch.data[SIZE_W-1:0];
            default: ;
         endcase
      end
   end

   ucrf_parser u_parser (
      .clock   (clock),
      .reset   (reset),
      .step    (advance),
      .byte_in (s1_byte_ff),
      .eop_in  (s1_eop_ff),
      .cfg     (cfg_ff),
      .cfg_nx  (cfg_in),
      .result  (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.listen_port <= '0;
         cfg_ff.magic_word  <= '0;
         cfg_ff.chunk_size  <= CHUNK_SIZE_RST;
         s1_valid_ff        <= 1'b0;
         rsp_valid_ff       <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
         if (req_ch.valid && req_ch.ready) begin
            s1_valid_ff <= 1'b1;
         end else if (advance) begin
            s1_valid_ff <= 1'b0;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.valid && req_ch.ready) begin
         s1_byte_ff <= req_ch.packet_byte;
         s1_eop_ff  <= req_ch.end_of_packet;
      end
      if (advance) begin
         rsp_ff <= result;
      end
   end

   assign rsp_ch.valid           = rsp_valid_ff;
   assign rsp_ch.write_enable    = rsp_ff.write_enable;
   assign rsp_ch.write_address   = rsp_ff.write_address;
   assign rsp_ch.write_data      = rsp_ff.write_data;
   assign rsp_ch.packet_done     = rsp_ff.packet_done;
   assign rsp_ch.packet_taken    = rsp_ff.packet_taken;
   assign rsp_ch.tensor_complete = rsp_ff.tensor_complete;
   assign rsp_ch.reply_port      = rsp_ff.reply_port;

   a_reset_empties: assert property (@(posedge clock)
      reset |=> !s1_valid_ff && !rsp_valid_ff)
      else $error("pipeline not empty after reset");

   a_advance_fills: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff)
      else $error("result lost after advance");

   a_taken_on_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.packet_taken |-> rsp_ff.packet_done)
      else $error("verdict outside last byte");

   a_complete_taken: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.tensor_complete |-> rsp_ff.packet_taken)
      else $error("tensor complete on packet not taken");

endmodule

// ----- sv/ucrf_parser.sv -----
module ucrf_parser (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          step,
   input  logic [ucrf_pkg::BYTE_W-1:0]   byte_in,
   input  logic                          eop_in,
   input  ucrf_pkg::cfg_type             cfg,
   input  ucrf_pkg::cfg_type             cfg_nx,
   output ucrf_pkg::result_type          result
);
   import ucrf_pkg::*;

   logic [POS_W-1:0]   pos_ff;
   logic [IHW_W-1:0]   ihw_ff, ihw_in;
   logic               udp_ff, udp_in;
   logic [PORT_W-1:0]  sport_ff, sport_in;
   logic               port_ok_ff, port_ok_in;
   logic [POS_W-1:0]   ulen_ff, ulen_in;
   logic               magic_ok_ff, magic_ok_in;
   logic [BYTE_W-1:0]  cidx_ff, cidx_in, cidx_nx;
   logic [BYTE_W-1:0]  ctot_ff, ctot_in;
   logic               fits_ff, fits_in;
   logic [PORT_W-1:0]  learned_ff, learned_in;
   logic [BASE_W-1:0]  base_ff, prod;
   logic [SIZE_W-1:0]  size_nx;

   logic [HOFS_W-1:0]  hofs;
   logic               ihl_ok, in_udp, checks, taken, we, below_end;
   logic [POS_W-1:0]   rel, ulen_m16, pay_ofs;
   logic [FIT_W-1:0]   fit_sum;

   assign ihw_in = (pos_ff == '0) ? byte_in[IHW_W-1:0] : ihw_ff;
   assign hofs   = {ihw_in, 2'b00};
   assign ihl_ok = ihw_in >= IHL_MIN;
   assign in_udp = pos_ff >= POS_W'(hofs);
   assign rel    = pos_ff - POS_W'(hofs);
   assign udp_in = (pos_ff == PROTO_POS) ? (byte_in == UDP_PROTO) : udp_ff;

   // base_ff always tracks chunk index times chunk size
   assign cidx_nx = !step ? cidx_ff : (eop_in ? '0 : cidx_in);
   assign size_nx = cfg_nx.chunk_size;
   assign prod    = BASE_W'(cidx_nx) * BASE_W'(size_nx);

   assign ulen_m16 = ulen_ff - PAYLOAD_OFS;
   assign fit_sum  = FIT_W'(prod) + FIT_W'(ulen_m16);

   always_comb begin
      sport_in    = sport_ff;
      port_ok_in  = port_ok_ff;
      ulen_in     = ulen_ff;
      magic_ok_in = magic_ok_ff;
      cidx_in     = cidx_ff;
      ctot_in     = ctot_ff;
      fits_in     = fits_ff;
      if (ihl_ok && in_udp) begin
         unique case (rel)
            REL_SPORT_HI: sport_in = {byte_in, 8'h00};
            REL_SPORT_LO: sport_in = {sport_ff[15:8], byte_in};
            REL_DPORT_HI: port_ok_in = byte_in == cfg.listen_port[15:8];
            REL_DPORT_LO: port_ok_in = port_ok_ff && (byte_in == cfg.listen_port[7:0]);
            REL_LEN_HI:   ulen_in = {byte_in, 8'h00};
            REL_LEN_LO:   ulen_in = {ulen_ff[15:8], byte_in};
            REL_MAGIC0:   magic_ok_in = byte_in == cfg.magic_word[31:24];
            REL_MAGIC1:   magic_ok_in = magic_ok_ff && (byte_in == cfg.magic_word[23:16]);
            REL_MAGIC2:   magic_ok_in = magic_ok_ff && (byte_in == cfg.magic_word[15:8]);
            REL_MAGIC3:   magic_ok_in = magic_ok_ff && (byte_in == cfg.magic_word[7:0]);
            REL_INDEX: begin
               cidx_in = byte_in;
               fits_in = (ulen_ff >= PAYLOAD_OFS) && (fit_sum <= FIT_W'(BUFFER_BYTES));
            end
            REL_TOTAL:    ctot_in = byte_in;
            default: ;
         endcase
      end
   end

   assign checks = ihl_ok && udp_in && port_ok_in && (ulen_in >= PAYLOAD_OFS) && magic_ok_in;
   assign learned_in = (ihl_ok && in_udp && rel == REL_TOTAL && checks) ? sport_in
                                                                       : learned_ff;
   assign taken     = ihl_ok && in_udp && (rel >= HDR_LAST) && checks;
   assign below_end = {1'b0, pos_ff} < ((POS_W+1)'(hofs) + {1'b0, ulen_in});
   assign we        = taken && fits_in && (rel >= PAYLOAD_OFS) && below_end
                      && (pos_ff != POS_MAX);
   assign pay_ofs   = rel - PAYLOAD_OFS;

   always_comb begin
      result.write_enable    = we;
      result.write_address   = we ? (base_ff[ADDR_W-1:0] + ADDR_W'(pay_ofs)) : '0;
      result.write_data      = we ? byte_in : '0;
      result.packet_done     = eop_in;
      result.packet_taken    = eop_in && taken;
      result.tensor_complete = eop_in && taken && fits_in
                               && ((9'(cidx_in) + 9'd1) == 9'(ctot_in));
      result.reply_port      = learned_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff      <= '0;
         ihw_ff      <= '0;
         udp_ff      <= 1'b0;
         sport_ff    <= '0;
         port_ok_ff  <= 1'b0;
         ulen_ff     <= '0;
         magic_ok_ff <= 1'b0;
         cidx_ff     <= '0;
         ctot_ff     <= '0;
         fits_ff     <= 1'b0;
         learned_ff  <= '0;
         base_ff     <= '0;
      end else begin
         base_ff <= prod;
         if (step) begin
            learned_ff <= learned_in;
            if (eop_in) begin
               pos_ff      <= '0;
               ihw_ff      <= '0;
               udp_ff      <= 1'b0;
               sport_ff    <= '0;
               port_ok_ff  <= 1'b0;
               ulen_ff     <= '0;
               magic_ok_ff <= 1'b0;
               cidx_ff     <= '0;
               ctot_ff     <= '0;
               fits_ff     <= 1'b0;
            end else begin
               if (pos_ff != POS_MAX) begin
                  pos_ff <= pos_ff + 16'd1;
               end
               ihw_ff      <= ihw_in;
               udp_ff      <= udp_in;
               sport_ff    <= sport_in;
               port_ok_ff  <= port_ok_in;
               ulen_ff     <= ulen_in;
               magic_ok_ff <= magic_ok_in;
               cidx_ff     <= cidx_in;
               ctot_ff     <= ctot_in;
               fits_ff     <= fits_in;
            end
         end
      end
   end

endmodule
